@@ sv/etc1_pkg.sv @@
`timescale 1ns / 1ps

package etc1_pkg;

  localparam int MaxDimDefault = 16384;
  localparam int CfgDimW = 15;
  localparam logic [CfgDimW-1:0] CfgDimReset = 15'd16384;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgImageWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSwapRedBlue = 2'd2;

  localparam logic [3:0] LastPos = 4'd15;

  // intensity modifier magnitudes per table code
  localparam logic [7:0] ModSmall [8] = '{8'd2, 8'd5, 8'd9, 8'd13, 8'd18, 8'd24, 8'd33, 8'd47};
  localparam logic [7:0] ModLarge [8] = '{8'd8, 8'd17, 8'd29, 8'd42, 8'd60, 8'd80, 8'd106,
                                          8'd183};

  typedef struct packed {
    logic [31:0] block_high;
    logic [31:0] block_low;
    logic [11:0] block_col;
    logic [11:0] block_row;
  } in_t;

  typedef struct packed {
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic        last_pixel;
  } out_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } rgb_t;

  typedef struct packed {
    logic [31:0] block_high;
    logic [31:0] block_low;
    logic [1:0]  dx;
    logic [1:0]  dy;
    logic        swap;
  } pix_req_t;

  // signed modifier for a table code and a two-bit pixel index
  function automatic logic signed [9:0] modifier(input logic [2:0] tab, input logic [1:0] sel);
    logic [9:0] mag;
    begin
      mag = sel[0] ? {2'b00, ModLarge[tab]} : {2'b00, ModSmall[tab]};
      modifier = sel[1] ? -$signed(mag) : $signed(mag);
    end
  endfunction

endpackage

@@ sv/etc1_pixel.sv @@
`timescale 1ns / 1ps

module etc1_pixel import etc1_pkg::*; (
  input  pix_req_t req,
  output rgb_t     rgb
);

  logic [31:0]       hi;
  logic [31:0]       lo;
  logic [3:0]        bit_idx;
  logic              sub;
  logic [1:0]        sel;
  logic [2:0]        tab;
  logic signed [9:0] m;
  logic [7:0]        base [3];
  logic [7:0]        chan [3];

  function automatic logic [7:0] sat_byte(input logic signed [9:0] v);
    begin
      if (v < 0) begin
        sat_byte = 8'd0;
      end else if (v > 10'sd255) begin
        sat_byte = 8'd255;
      end else begin
        sat_byte = v[7:0];
      end
    end
  endfunction

  always_comb begin
    hi = req.block_high;
    lo = req.block_low;
    bit_idx = {req.dx, req.dy};
    sub = hi[0] ? req.dy[1] : req.dx[1];
    sel = {lo[5'd16 + {1'b0, bit_idx}], lo[bit_idx]};
    tab = sub ? hi[4:2] : hi[7:5];
    m = modifier(tab, sel);
  end

  // base color of the selected subblock, channel 0 = red, 1 = green, 2 = blue
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [4:0] e1;
      logic [2:0] d;
      logic [7:0] e2;
      logic [3:0] a;
      logic [3:0] b;
      e1 = hi[31 - 8 * c -: 5];
      d = hi[26 - 8 * c -: 3];
      e2 = {3'b000, e1} + {{5{d[2]}}, d};
      a = hi[31 - 8 * c -: 4];
      b = hi[27 - 8 * c -: 4];
      if (hi[1]) begin
        base[c] = sub ? ({e2[4:0], 3'b000} | {2'b00, e2[7:2]})
                      : ({e1, 3'b000} | {5'b00000, e1[4:2]});
      end else begin
        base[c] = sub ? {b, b} : {a, a};
      end
      chan[c] = sat_byte($signed({2'b00, base[c]}) + m);
    end
  end

  assign rgb.chan0 = req.swap ? chan[0] : chan[2];
  assign rgb.chan1 = chan[1];
  assign rgb.chan2 = req.swap ? chan[2] : chan[0];

endmodule

@@ sv/etc1_block_decoder.sv @@
`timescale 1ns / 1ps

// ETC1 block decoder: each accepted 64-bit block is walked over its sixteen
// pixel positions in row-major order, one position per clock unless a stall
// holds it, and the next block is taken in the same cycle as the last
// position of the current one. Pixels outside the image width and height
// are dropped, which leaves a gap cycle on the result side; the last pixel
// emitted for a block carries last_pixel. A result register separates the
// pixel datapath from out_stall, and a stall holds the walk. Configuration
// must be written only while the decoder is idle; the block does not enforce it.

module etc1_block_decoder import etc1_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDimW-1:0] cfg_data
);

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int CmpW = (DimW > CfgDimW) ? DimW : CfgDimW;
  localparam logic [CmpW-1:0] DimLimit = CmpW'(MAX_DIM);

  logic [CfgDimW-1:0] width_r;
  logic [CfgDimW-1:0] height_r;
  logic               swap_r;

  logic               busy_r;
  logic [3:0]         cnt_r;
  logic [31:0]        hi_r;
  logic [31:0]        lo_r;
  logic [11:0]        col_r;
  logic [11:0]        row_r;
  logic [2:0]         ncols_r;
  logic [2:0]         nrows_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic [CmpW-1:0]    w_sat;
  logic [CmpW-1:0]    h_sat;
  logic [CmpW-1:0]    x_org;
  logic [CmpW-1:0]    y_org;
  logic [CmpW-1:0]    w_rem;
  logic [CmpW-1:0]    h_rem;
  logic [2:0]         ncols_nxt;
  logic [2:0]         nrows_nxt;

  logic               adv;
  logic               step;
  logic               in_acc;
  logic [1:0]         dx;
  logic [1:0]         dy;
  logic               emit;
  logic               last;
  pix_req_t           req;
  rgb_t               rgb;

  // number of block columns and rows inside the image
  always_comb begin
    w_sat = (CmpW'(width_r) > DimLimit) ? DimLimit : CmpW'(width_r);
    h_sat = (CmpW'(height_r) > DimLimit) ? DimLimit : CmpW'(height_r);
    x_org = CmpW'({in_data.block_col, 2'b00});
    y_org = CmpW'({in_data.block_row, 2'b00});
    w_rem = w_sat - x_org;
    h_rem = h_sat - y_org;
    if (w_sat <= x_org) begin
      ncols_nxt = 3'd0;
    end else if (w_rem >= CmpW'(4)) begin
      ncols_nxt = 3'd4;
    end else begin
      ncols_nxt = w_rem[2:0];
    end
    if (h_sat <= y_org) begin
      nrows_nxt = 3'd0;
    end else if (h_rem >= CmpW'(4)) begin
      nrows_nxt = 3'd4;
    end else begin
      nrows_nxt = h_rem[2:0];
    end
  end

  assign adv = !out_valid_r || !out_stall;
  assign step = busy_r && adv;
  assign in_stall = busy_r && !(adv && (cnt_r == LastPos));
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign dy = cnt_r[3:2];
  assign dx = cnt_r[1:0];
  assign emit = ({1'b0, dx} < ncols_r) && ({1'b0, dy} < nrows_r);
  assign last = ({1'b0, dx} == ncols_r - 3'd1) && ({1'b0, dy} == nrows_r - 3'd1);

  assign req.block_high = hi_r;
  assign req.block_low = lo_r;
  assign req.dx = dx;
  assign req.dy = dy;
  assign req.swap = swap_r;

  etc1_pixel u_pixel (
    .req (req),
    .rgb (rgb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CfgDimReset;
      height_r <= CfgDimReset;
      swap_r <= 1'b0;
      busy_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgImageWidth: width_r <= cfg_data;
          CfgImageHeight: height_r <= cfg_data;
          CfgSwapRedBlue: swap_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (step) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == LastPos) begin
          busy_r <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_r <= step && emit;
      end
    end
  end

  // block and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hi_r <= in_data.block_high;
      lo_r <= in_data.block_low;
      col_r <= in_data.block_col;
      row_r <= in_data.block_row;
      ncols_r <= ncols_nxt;
      nrows_r <= nrows_nxt;
    end
    if (step && emit) begin
      out_data_r.pixel_x <= {col_r, dx};
      out_data_r.pixel_y <= {row_r, dy};
      out_data_r.chan0 <= rgb.chan0;
      out_data_r.chan1 <= rgb.chan1;
      out_data_r.chan2 <= rgb.chan2;
      out_data_r.last_pixel <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

@@ verif/etc1_block_decoder_tb.sv @@
`timescale 1ns / 1ps

module etc1_block_decoder_tb;
  import etc1_pkg::*;

  localparam int LongHold = 300;
  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 40;

  // modifier per table code, indexed by the two-bit pixel index {msb, lsb}
  localparam int PixelOffset [8][4] = '{
    '{2, 8, -2, -8}, '{5, 17, -5, -17}, '{9, 29, -9, -29}, '{13, 42, -13, -42},
    '{18, 60, -18, -60}, '{24, 80, -24, -80}, '{33, 106, -33, -106},
    '{47, 183, -47, -183}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDimW-1:0] cfg_data = '0;

  logic [CfgDimW-1:0] img_w = CfgDimReset;
  logic [CfgDimW-1:0] img_h = CfgDimReset;
  logic               swap_rb = 1'b0;

  in_t  blocks_to_send [$];
  out_t expected_pixels [$];

  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int long_hold_req = 0;
  int long_hold_seen = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  bit src_quiet = 1'b0;
  bit dst_quiet = 1'b0;

  etc1_block_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] widen5(input logic [7:0] c);
    return (c << 3) | (c >> 2);
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic void decode_block(input in_t blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [7:0]  base [2][3];
    logic [2:0]  tab [2];
    logic [4:0]  e1;
    logic [2:0]  dlt;
    logic [7:0]  e2;
    logic [1:0]  sel;
    int          top, w, h, x, y, sub, m, bitpos, c, dx, dy;
    int          rgb [3];
    out_t        px;
    out_t        pixels [$];
    hi = blk.block_high;
    lo = blk.block_low;
    for (c = 0; c < 3; c++) begin
      top = 31 - 8 * c;
      if (hi[1]) begin
        e1 = 5'(hi >> (top - 4));
        dlt = 3'(hi >> (top - 7));
        e2 = {3'b000, e1} + {{5{dlt[2]}}, dlt};
        base[0][c] = widen5({3'b000, e1});
        base[1][c] = widen5(e2);
      end else begin
        base[0][c] = {2{4'(hi >> (top - 3))}};
        base[1][c] = {2{4'(hi >> (top - 7))}};
      end
    end
    tab[0] = hi[7:5];
    tab[1] = hi[4:2];
    w = (int'(img_w) > MaxDimDefault) ? MaxDimDefault : int'(img_w);
    h = (int'(img_h) > MaxDimDefault) ? MaxDimDefault : int'(img_h);
    for (dy = 0; dy < 4; dy++) begin
      for (dx = 0; dx < 4; dx++) begin
        x = int'(blk.block_col) * 4 + dx;
        y = int'(blk.block_row) * 4 + dy;
        if (x >= w || y >= h) continue;
        bitpos = dx * 4 + dy;
        sub = hi[0] ? dy / 2 : dx / 2;
        sel = {lo[16 + bitpos], lo[bitpos]};
        m = PixelOffset[tab[sub]][sel];
        for (c = 0; c < 3; c++) rgb[c] = int'(base[sub][c]) + m;
        px.pixel_x = 14'(x);
        px.pixel_y = 14'(y);
        px.chan0 = swap_rb ? clamp_byte(rgb[0]) : clamp_byte(rgb[2]);
        px.chan1 = clamp_byte(rgb[1]);
        px.chan2 = swap_rb ? clamp_byte(rgb[2]) : clamp_byte(rgb[0]);
        px.last_pixel = 1'b0;
        pixels.push_back(px);
      end
    end
    if (pixels.size() > 0) pixels[pixels.size() - 1].last_pixel = 1'b1;
    foreach (pixels[i]) expected_pixels.push_back(pixels[i]);
  endfunction

  function automatic void check_pixel(input out_t got);
    out_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel transfer at x %0d y %0d", got.pixel_x, got.pixel_y);
      fail_count++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x) begin
      $error("pixel_x mismatch: expected %0d, got %0d", want.pixel_x, got.pixel_x);
      fail_count++;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $error("pixel_y mismatch: expected %0d, got %0d", want.pixel_y, got.pixel_y);
      fail_count++;
    end
    if (got.chan0 !== want.chan0) begin
      $error("chan0 mismatch: expected %0d, got %0d", want.chan0, got.chan0);
      fail_count++;
    end
    if (got.chan1 !== want.chan1) begin
      $error("chan1 mismatch: expected %0d, got %0d", want.chan1, got.chan1);
      fail_count++;
    end
    if (got.chan2 !== want.chan2) begin
      $error("chan2 mismatch: expected %0d, got %0d", want.chan2, got.chan2);
      fail_count++;
    end
    if (got.last_pixel !== want.last_pixel) begin
      $error("last_pixel mismatch: expected %0d, got %0d", want.last_pixel, got.last_pixel);
      fail_count++;
    end
  endfunction

  // block sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_block(in_data);
        send_wait = src_quiet ? 0 : $urandom_range(0, 15);
      end
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (blocks_to_send.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= blocks_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_pixel(out_data);
        recv_wait = dst_quiet ? 0 : $urandom_range(0, 15);
      end
      if (long_hold_seen != long_hold_req) begin
        long_hold_seen = long_hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t pack_block(input logic [31:0] hi, input logic [31:0] lo,
                                     input logic [11:0] col, input logic [11:0] row);
    in_t b;
    b.block_high = hi;
    b.block_low = lo;
    b.block_col = col;
    b.block_row = row;
    return b;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDimW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CfgImageWidth:  img_w = val;
      CfgImageHeight: img_h = val;
      CfgSwapRedBlue: swap_rb = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_image(input int w, input int h, input bit swap);
    write_reg(CfgImageWidth, CfgDimW'(w));
    write_reg(CfgImageHeight, CfgDimW'(h));
    write_reg(CfgSwapRedBlue, CfgDimW'(swap));
  endtask

  // wait until every block is taken and every pixel has come back
  task automatic settle();
    while (blocks_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_random(input int count, input int max_col, input int max_row);
    repeat (count) begin
      blocks_to_send.push_back(pack_block($urandom, $urandom,
                                          12'($urandom_range(0, max_col)),
                                          12'($urandom_range(0, max_row))));
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_image(16384, 16384, 1'b0);
    blocks_to_send.push_back(pack_block(32'h0, 32'h0, 12'd0, 12'd0));
    blocks_to_send.push_back(pack_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd4095, 12'd4095));
    for (int t = 0; t < 8; t++) begin
      blocks_to_send.push_back(pack_block({24'($urandom), 3'(t), 3'(7 - t), 1'(t >> 1), 1'(t)},
                                          $urandom, 12'(t), 12'(7 - t)));
    end
    blocks_to_send.push_back(pack_block(32'h4A93_C1E6, 32'h0000_FFFF, 12'd4095, 12'd0));
    blocks_to_send.push_back(pack_block(32'h4A93_C1E5, 32'hFFFF_0000, 12'd0, 12'd4095));
    // differential sum below zero and above 31
    blocks_to_send.push_back(pack_block(32'h0404_04E2, 32'h0F0F_F0F0, 12'd3, 12'd3));
    blocks_to_send.push_back(pack_block(32'hFBFB_FB1F, 32'hA5A5_5A5A, 12'd5, 12'd9));
    // individual mode saturating both ways, and one differential-mode block
    blocks_to_send.push_back(pack_block(32'hF0F0_F0FD, 32'hFFFF_0000, 12'd1, 12'd1));
    blocks_to_send.push_back(pack_block(32'hF0F0_F0FC, 32'h0000_FFFF, 12'd2, 12'd2));
    blocks_to_send.push_back(pack_block(32'h0F0F_0F1C, 32'hFFFF_FFFF, 12'd6, 12'd6));
    blocks_to_send.push_back(pack_block(32'h0707_07FE, 32'h0000_0000, 12'd7, 12'd0));
    settle();

    // receiver holds off while blocks keep coming
    set_image(32767, 16384, 1'b1);
    long_hold_req++;
    send_random(40, 4095, 4095);

    set_image(0, 100, 1'b1);
    send_random(10, 20, 20);

    set_image(1, 1, 1'b0);
    send_random(20, 1, 1);

    src_quiet = 1'b1;
    dst_quiet = 1'b1;
    set_image($urandom_range(1, 60), $urandom_range(1, 60), 1'($urandom));
    send_random(60, 16, 16);
    src_quiet = 1'b0;
    dst_quiet = 1'b0;

    set_image(16384, 0, 1'b0);
    send_random(5, 8, 8);

    set_image(13, 7, 1'b1);
    send_random(60, 4, 2);

    src_quiet = 1'b1;
    set_image(16384, 16384, 1'($urandom));
    send_random(60, 4095, 4095);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
